/* rtl/gn2d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared types, constants and gradient lookup for the 2D gradient noise block.
// ----------------------------------------------------------------------------
package gn2d_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int TABLE_AW    = 9;
	localparam int PIPE_DEPTH  = 12;

	typedef logic signed [17:0] grad_t;
	typedef logic signed [16:0] frac_t;
	typedef logic signed [19:0] fade_t;
	typedef logic signed [20:0] dot_t;
	typedef logic signed [17:0] elev_t;
	typedef logic [TABLE_AW-1:0] taddr_t;
	typedef logic [7:0] perm_t;

	localparam grad_t ONE_Q16  = 18'sd65536;
	localparam grad_t DIAG_Q16 = 18'sd46341;
	localparam elev_t ELEV_MAX = 18'sd131071;
	localparam elev_t ELEV_MIN = -18'sd131072;

	localparam logic KIND_EVAL = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	function automatic grad_t grad_x(input logic [2:0] g);
		grad_t r;
		case (g)
			3'd0: r = DIAG_Q16;
			3'd1: r = -DIAG_Q16;
			3'd2: r = DIAG_Q16;
			3'd3: r = -DIAG_Q16;
			3'd4: r = ONE_Q16;
			3'd5: r = -ONE_Q16;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic grad_t grad_y(input logic [2:0] g);
		grad_t r;
		case (g)
			3'd0: r = DIAG_Q16;
			3'd1: r = DIAG_Q16;
			3'd2: r = -DIAG_Q16;
			3'd3: r = -DIAG_Q16;
			3'd6: r = ONE_Q16;
			3'd7: r = -ONE_Q16;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/gn2d_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_req_if
// Request channel: evaluate or table load items.
// ----------------------------------------------------------------------------
interface gn2d_req_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic [8:0]         table_index;
	logic [7:0]         table_value;

	modport source (output valid, kind, coord_x, coord_y, table_index, table_value,
		input ready);
	modport sink (input valid, kind, coord_x, coord_y, table_index, table_value,
		output ready);
endinterface

/* rtl/gn2d_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_res_if
// Result channel: one elevation item per evaluate item.
// ----------------------------------------------------------------------------
interface gn2d_res_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] elevation;

	modport source (output valid, elevation, input ready);
	modport sink (input valid, elevation, output ready);
endinterface

/* rtl/gn2d_fade.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_fade
// Three-stage fade curve 3t^2-2t^3, Q.16 in, Q.16 out, truncated toward zero.
// ----------------------------------------------------------------------------
module gn2d_fade (
	input  logic                 clk,
	input  logic [2:0]           adv,
	input  gn2d_pkg::frac_t      t,
	output gn2d_pkg::fade_t      fade
);

	logic signed [33:0] t2_w;
	logic signed [33:0] t2_s1;
	logic signed [16:0] t_s1;
	logic signed [50:0] t3_w;
	logic signed [50:0] t3_s2;
	logic signed [33:0] t2_s2;
	logic signed [51:0] a_w;
	logic signed [51:0] c_w;
	gn2d_pkg::fade_t    f_w;
	gn2d_pkg::fade_t    fade_s3;

	assign t2_w = t * t;
	assign t3_w = t2_s1 * t_s1;
	assign a_w  = {{18{t2_s2[33]}}, t2_s2} <<< 16;
	assign c_w  = a_w + (a_w <<< 1) - ({t3_s2[50], t3_s2} <<< 1);
	// truncate toward zero: bump floor when negative with a nonzero remainder
	assign f_w  = c_w[51:32] + {19'd0, (c_w[51] && (|c_w[31:0]))};

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			t2_s1 <= t2_w;
			t_s1  <= t;
		end
		if (adv[1]) begin
			t3_s2 <= t3_w;
			t2_s2 <= t2_s1;
		end
		if (adv[2]) begin
			fade_s3 <= f_w;
		end
	end

	assign fade = fade_s3;

endmodule

/* rtl/gradient_noise_2d.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2D gradient noise over a loadable 512-entry permutation table.
// ----------------------------------------------------------------------------
// Takes one item per clock unless a stalled result backs up the pipeline; an
// elevation is computed by the twelve-stage pipeline (capture, scale,
// rescale, split, row lookup, corner lookup, gradient products, dot products,
// two x blend stages, two y blend stages). Per-stage valid bits mean a stalled
// result only backs up stages behind it and bubbles are squeezed out. Load
// items (kind = 1) write the permutation table in pipeline order and give no
// result; an evaluate item issued right after a load sees the new entry. The
// table is held in three copies, each written by every load: one serves the
// two row lookups, two serve the four corner lookups. Its contents are
// undefined until loaded, and every entry an evaluate touches must be loaded
// first. Write inverse_resolution only while no item is in flight.
// ----------------------------------------------------------------------------
module gradient_noise_2d #(
	parameter int GRID_PERIOD = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        inverse_resolution_we,
	input  logic [31:0] inverse_resolution_wdata,
	gn2d_req_if.sink    request,
	gn2d_res_if.source  result
);

	// cell mask reduced to table address width; upper bits wrap away anyway
	localparam gn2d_pkg::taddr_t CELL_MASK = gn2d_pkg::taddr_t'(GRID_PERIOD - 1);

	logic [31:0] inv_res_q;

	// stage advance enables and valid bits
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9, adv10, adv11, adv12;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic valid_s7, valid_s8, valid_s9, valid_s10, valid_s11, valid_s12;

	// load payload rides along through stage 6
	logic kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	gn2d_pkg::taddr_t idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	gn2d_pkg::perm_t  val_s1, val_s2, val_s3, val_s4, val_s5;

	logic signed [31:0] x_s1, y_s1;
	logic signed [64:0] mx_w, my_w;
	logic signed [63:0] px_s2, py_s2;
	logic signed [47:0] qx_s3, qy_s3;

	gn2d_pkg::taddr_t ii_w, jj_w, ii_s4, jj_s4, ii_s5;
	gn2d_pkg::frac_t  fx_w, fy_w, fx_s4, fy_s4, fx_s5, fy_s5, fx_s6, fy_s6;
	gn2d_pkg::perm_t  row0_s5, row1_s5;
	gn2d_pkg::perm_t  g_s6 [4];

	gn2d_pkg::perm_t tab_a [gn2d_pkg::TABLE_DEPTH];
	gn2d_pkg::perm_t tab_b [gn2d_pkg::TABLE_DEPTH];
	gn2d_pkg::perm_t tab_c [gn2d_pkg::TABLE_DEPTH];

	gn2d_pkg::taddr_t a00_w, a10_w, a01_w, a11_w;

	logic signed [17:0] dx_w [4];
	logic signed [17:0] dy_w [4];
	logic signed [35:0] prx_w [4];
	logic signed [35:0] pry_w [4];
	logic signed [35:0] prx_s7 [4];
	logic signed [35:0] pry_s7 [4];
	logic signed [36:0] dsum_w [4];
	gn2d_pkg::dot_t     dot_w [4];
	gn2d_pkg::dot_t     dot_s8 [4];

	gn2d_pkg::fade_t fade_x_s7, fade_y_s7;
	gn2d_pkg::fade_t fade_x_s8;
	gn2d_pkg::fade_t fade_y_s8, fade_y_s9, fade_y_s10;

	logic signed [21:0] dtop_w, dbot_w;
	logic signed [41:0] p1_w, p2_w, p1_s9, p2_s9;
	gn2d_pkg::dot_t     d0_s9, d2_s9;
	logic signed [26:0] sx_w, bx_w, sx_s10, bx_s10, sx_s11;
	logic signed [27:0] dy2_w;
	logic signed [47:0] p3_w, p3_s11;
	logic signed [32:0] e_w;
	gn2d_pkg::elev_t    elev_w, elev_s12;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_res_q <= 32'd65536;
		end else if (inverse_resolution_we) begin
			inv_res_q <= inverse_resolution_wdata;
		end
	end

	// each stage moves when empty or when the one after it moves
	assign adv12 = !valid_s12 || result.ready;
	assign adv11 = !valid_s11 || adv12;
	assign adv10 = !valid_s10 || adv11;
	assign adv9  = !valid_s9  || adv10;
	assign adv8  = !valid_s8  || adv9;
	assign adv7  = !valid_s7  || adv8;
	assign adv6  = !valid_s6  || adv7;
	assign adv5  = !valid_s5  || adv6;
	assign adv4  = !valid_s4  || adv5;
	assign adv3  = !valid_s3  || adv4;
	assign adv2  = !valid_s2  || adv3;
	assign adv1  = !valid_s1  || adv2;

	assign request.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else begin
			if (adv1)  valid_s1  <= request.valid;
			if (adv2)  valid_s2  <= valid_s1;
			if (adv3)  valid_s3  <= valid_s2;
			if (adv4)  valid_s4  <= valid_s3;
			if (adv5)  valid_s5  <= valid_s4;
			if (adv6)  valid_s6  <= valid_s5;
			// loads are done after the corner table write and leave here
			if (adv7)  valid_s7  <= valid_s6 && (kind_s6 == gn2d_pkg::KIND_EVAL);
			if (adv8)  valid_s8  <= valid_s7;
			if (adv9)  valid_s9  <= valid_s8;
			if (adv10) valid_s10 <= valid_s9;
			if (adv11) valid_s11 <= valid_s10;
			if (adv12) valid_s12 <= valid_s11;
		end
	end

	// stage 1: capture
	always_ff @(posedge clk) begin
		if (adv1) begin
			kind_s1 <= request.kind;
			x_s1    <= request.coord_x;
			y_s1    <= request.coord_y;
			idx_s1  <= request.table_index;
			val_s1  <= request.table_value;
		end
	end

	// stage 2: scale by the reciprocal resolution, exact Q32.32
	assign mx_w = x_s1 * $signed({1'b0, inv_res_q});
	assign my_w = y_s1 * $signed({1'b0, inv_res_q});

	always_ff @(posedge clk) begin
		if (adv2) begin
			kind_s2 <= kind_s1;
			idx_s2  <= idx_s1;
			val_s2  <= val_s1;
			px_s2   <= mx_w[63:0];
			py_s2   <= my_w[63:0];
		end
	end

	// stage 3: back to Q.16, toward zero
	always_ff @(posedge clk) begin
		if (adv3) begin
			kind_s3 <= kind_s2;
			idx_s3  <= idx_s2;
			val_s3  <= val_s2;
			qx_s3   <= px_s2[63:16] + {47'd0, (px_s2[63] && (|px_s2[15:0]))};
			qy_s3   <= py_s2[63:16] + {47'd0, (py_s2[63] && (|py_s2[15:0]))};
		end
	end

	// stage 4: split into cell and signed fraction (truncating division)
	always_comb begin
		logic nx, ny;
		nx   = qx_s3[47] && (|qx_s3[15:0]);
		ny   = qy_s3[47] && (|qy_s3[15:0]);
		ii_w = (qx_s3[24:16] + {8'd0, nx}) & CELL_MASK;
		jj_w = (qy_s3[24:16] + {8'd0, ny}) & CELL_MASK;
		fx_w = {nx, qx_s3[15:0]};
		fy_w = {ny, qy_s3[15:0]};
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			kind_s4 <= kind_s3;
			idx_s4  <= idx_s3;
			val_s4  <= val_s3;
			ii_s4   <= ii_w;
			jj_s4   <= jj_w;
			fx_s4   <= fx_w;
			fy_s4   <= fy_w;
		end
	end

	// stage 5: row lookups; a load writes the row copy as it passes here
	always_ff @(posedge clk) begin
		if (adv5) begin
			if (valid_s4 && (kind_s4 == gn2d_pkg::KIND_LOAD)) begin
				tab_a[idx_s4] <= val_s4;
			end
			row0_s5 <= tab_a[jj_s4];
			row1_s5 <= tab_a[jj_s4 + gn2d_pkg::taddr_t'(1)];
			kind_s5 <= kind_s4;
			idx_s5  <= idx_s4;
			val_s5  <= val_s4;
			ii_s5   <= ii_s4;
			fx_s5   <= fx_s4;
			fy_s5   <= fy_s4;
		end
	end

	// stage 6: corner lookups, addresses wrap modulo the table depth
	assign a00_w = ii_s5 + {1'b0, row0_s5};
	assign a10_w = ii_s5 + {1'b0, row0_s5} + gn2d_pkg::taddr_t'(1);
	assign a01_w = ii_s5 + {1'b0, row1_s5};
	assign a11_w = ii_s5 + {1'b0, row1_s5} + gn2d_pkg::taddr_t'(1);

	always_ff @(posedge clk) begin
		if (adv6) begin
			if (valid_s5 && (kind_s5 == gn2d_pkg::KIND_LOAD)) begin
				tab_b[idx_s5] <= val_s5;
				tab_c[idx_s5] <= val_s5;
			end
			g_s6[0] <= tab_b[a00_w];
			g_s6[1] <= tab_b[a10_w];
			g_s6[2] <= tab_c[a01_w];
			g_s6[3] <= tab_c[a11_w];
			kind_s6 <= kind_s5;
			fx_s6   <= fx_s5;
			fy_s6   <= fy_s5;
		end
	end

	// fade curves run alongside stages 5 to 7
	gn2d_fade u_fade_x (
		.clk  (clk),
		.adv  ({adv7, adv6, adv5}),
		.t    (fx_s4),
		.fade (fade_x_s7)
	);

	gn2d_fade u_fade_y (
		.clk  (clk),
		.adv  ({adv7, adv6, adv5}),
		.t    (fy_s4),
		.fade (fade_y_s7)
	);

	// stage 7: gradient times corner offset, one product per axis per corner
	always_comb begin
		dx_w[0] = {fx_s6[16], fx_s6};
		dx_w[1] = {fx_s6[16], fx_s6} - gn2d_pkg::ONE_Q16;
		dx_w[2] = dx_w[0];
		dx_w[3] = dx_w[1];
		dy_w[0] = {fy_s6[16], fy_s6};
		dy_w[1] = dy_w[0];
		dy_w[2] = {fy_s6[16], fy_s6} - gn2d_pkg::ONE_Q16;
		dy_w[3] = dy_w[2];
		for (int k = 0; k < 4; k++) begin
			prx_w[k] = gn2d_pkg::grad_x(g_s6[k][2:0]) * dx_w[k];
			pry_w[k] = gn2d_pkg::grad_y(g_s6[k][2:0]) * dy_w[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv7) begin
			for (int k = 0; k < 4; k++) begin
				prx_s7[k] <= prx_w[k];
				pry_s7[k] <= pry_w[k];
			end
		end
	end

	// stage 8: dot products back to Q.16
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dsum_w[k] = {prx_s7[k][35], prx_s7[k]} + {pry_s7[k][35], pry_s7[k]};
			dot_w[k]  = dsum_w[k][36:16]
				+ {20'd0, (dsum_w[k][36] && (|dsum_w[k][15:0]))};
		end
	end

	always_ff @(posedge clk) begin
		if (adv8) begin
			for (int k = 0; k < 4; k++) begin
				dot_s8[k] <= dot_w[k];
			end
			fade_x_s8 <= fade_x_s7;
			fade_y_s8 <= fade_y_s7;
		end
	end

	// stage 9: x blend products
	assign dtop_w = {dot_s8[1][20], dot_s8[1]} - {dot_s8[0][20], dot_s8[0]};
	assign dbot_w = {dot_s8[3][20], dot_s8[3]} - {dot_s8[2][20], dot_s8[2]};
	assign p1_w   = fade_x_s8 * dtop_w;
	assign p2_w   = fade_x_s8 * dbot_w;

	always_ff @(posedge clk) begin
		if (adv9) begin
			p1_s9     <= p1_w;
			p2_s9     <= p2_w;
			d0_s9     <= dot_s8[0];
			d2_s9     <= dot_s8[2];
			fade_y_s9 <= fade_y_s8;
		end
	end

	// stage 10: finish the x blends
	assign sx_w = {{6{d0_s9[20]}}, d0_s9} + {p1_s9[41], p1_s9[41:16]}
		+ {26'd0, (p1_s9[41] && (|p1_s9[15:0]))};
	assign bx_w = {{6{d2_s9[20]}}, d2_s9} + {p2_s9[41], p2_s9[41:16]}
		+ {26'd0, (p2_s9[41] && (|p2_s9[15:0]))};

	always_ff @(posedge clk) begin
		if (adv10) begin
			sx_s10     <= sx_w;
			bx_s10     <= bx_w;
			fade_y_s10 <= fade_y_s9;
		end
	end

	// stage 11: y blend product
	assign dy2_w = {bx_s10[26], bx_s10} - {sx_s10[26], sx_s10};
	assign p3_w  = fade_y_s10 * dy2_w;

	always_ff @(posedge clk) begin
		if (adv11) begin
			p3_s11 <= p3_w;
			sx_s11 <= sx_s10;
		end
	end

	// stage 12: finish y blend and clamp to Q2.16
	always_comb begin
		e_w = {{6{sx_s11[26]}}, sx_s11} + {p3_s11[47], p3_s11[47:16]}
			+ {32'd0, (p3_s11[47] && (|p3_s11[15:0]))};
		if (e_w > 33'sd131071) begin
			elev_w = gn2d_pkg::ELEV_MAX;
		end else if (e_w < -33'sd131072) begin
			elev_w = gn2d_pkg::ELEV_MIN;
		end else begin
			elev_w = e_w[17:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv12) begin
			elev_s12 <= elev_w;
		end
	end

	assign result.valid     = valid_s12;
	assign result.elevation = elev_s12;

endmodule

/* rtl/gn2d_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_chk
// Port-level checks for the gradient noise block, bound to the top level.
// ----------------------------------------------------------------------------
module gn2d_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               req_kind,
	input logic               res_valid,
	input logic               res_ready,
	input logic signed [17:0] res_elevation
);

	logic [4:0] pending_q;
	logic       eval_acc;
	logic       res_acc;

	assign eval_acc = req_valid && req_ready && (req_kind == gn2d_pkg::KIND_EVAL);
	assign res_acc  = res_valid && res_ready;

	// evaluate items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {4'd0, eval_acc} - {4'd0, res_acc};
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_elevation))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 5'd0)
		else $error("result without an outstanding evaluate item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 5'(gn2d_pkg::PIPE_DEPTH))
		else $error("more evaluate items in flight than pipeline stages");

endmodule

bind gradient_noise_2d gn2d_chk u_gn2d_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (request.valid),
	.req_ready     (request.ready),
	.req_kind      (request.kind),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_elevation (result.elevation)
);
